FILE: rtl/core/gsf_pkg.sv
package gsf_pkg;

   localparam int SAMPLE_W     = 24;
   localparam int WEIGHT_W     = 18;
   localparam int TAP_IDX_W    = 6;
   localparam int WIN_W        = 6;
   localparam int HALF_W       = WIN_W - 1;
   localparam int FRAC_W       = 17;
   localparam int PROD_W       = SAMPLE_W + WEIGHT_W;
   localparam int ACC_W        = PROD_W + 6;
   localparam int CNT_MAX      = 63;
   localparam int DEF_MAX_TAPS = 63;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_MODE    = 1'd1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_COEF = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

   typedef struct packed {
      logic                 coef_wr;
      logic                 start;
      logic                 push_sample;
      logic                 push_pad;
      logic                 pad_zero;
      logic                 tap_rd;
      logic [WIN_W-1:0]     tap;
      logic [WIN_W-1:0]     age;
      logic                 load_fir;
      logic                 load_pass;
      logic                 out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

FILE: rtl/core/gsf_if.sv
interface gsf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [gsf_pkg::SAMPLE_W-1:0]  sample;
   logic                                 last_sample;
   logic [gsf_pkg::TAP_IDX_W-1:0]        tap_index;
   logic [gsf_pkg::WEIGHT_W-1:0]         tap_weight;

   modport source (output valid, kind, sample, last_sample, tap_index, tap_weight,
                   input ready);
   modport sink   (input valid, kind, sample, last_sample, tap_index, tap_weight,
                   output ready);
endinterface

interface gsf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gsf_pkg::SAMPLE_W-1:0]  smoothed;
   logic                                 last_out;

   modport source (output valid, smoothed, last_out, input ready);
   modport sink   (input valid, smoothed, last_out, output ready);
endinterface

FILE: rtl/core/gsf_ctrl.sv
module gsf_ctrl #(
   parameter int MAX_TAPS = gsf_pkg::DEF_MAX_TAPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_kind,
   input  logic                              req_last_sample,
   output logic                              req_ready,
   input  logic                              csr_we,
   input  logic [gsf_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [gsf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output gsf_pkg::dp_cmd_type               cmd,
   input  gsf_pkg::dp_stat_type              stat
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_SHIFT = 7'b0000100,
      ST_ISSUE = 7'b0001000,
      ST_DRAIN = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_PASS  = 7'b1000000
   } state_type;

   localparam int WW = gsf_pkg::WIN_W;
   localparam int HW = gsf_pkg::HALF_W;

   state_type         state_ff, state_in;
   logic              series_ff, series_in;
   logic [WW-1:0]     seen_ff, seen_in;
   logic [HW-1:0]     half_ff, half_in;
   logic              last_ff, last_in;
   logic [WW-1:0]     pre_ff, pre_in;
   logic [WW-1:0]     rem_ff, rem_in;
   logic [WW-1:0]     tap_ff, tap_in;
   logic              drain_ff, drain_in;
   logic [WW-1:0]     window_ff;
   logic              pad_mode_ff;

   logic              accept;
   logic [WW-1:0]     cnt_now;
   logic [WW-1:0]     win_eff;
   logic [HW-1:0]     half_now;
   logic [WW-1:0]     half_p1;
   logic [WW-1:0]     res_cnt;
   logic [WW-1:0]     span;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign span      = {half_ff, 1'b0};

   always_comb begin
      if (!series_ff) begin
         cnt_now = WW'(1);
      end else if (32'(seen_ff) < gsf_pkg::CNT_MAX) begin
         cnt_now = seen_ff + 1'b1;
      end else begin
         cnt_now = seen_ff;
      end
      if (32'(window_ff) > 32'(MAX_TAPS)) begin
         win_eff = WW'(MAX_TAPS);
      end else begin
         win_eff = window_ff;
      end
      half_now = HW'((win_eff - 1'b1) >> 1);
      half_p1  = {1'b0, half_now} + 1'b1;
      res_cnt  = (cnt_now < half_p1) ? cnt_now : half_p1;
   end

   always_comb begin
      state_in  = state_ff;
      series_in = series_ff;
      seen_in   = seen_ff;
      half_in   = half_ff;
      last_in   = last_ff;
      pre_in    = pre_ff;
      rem_in    = rem_ff;
      tap_in    = tap_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.pad_zero = !pad_mode_ff;
      cmd.tap      = tap_ff;
      cmd.age      = span - tap_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == gsf_pkg::KIND_COEF) begin
               cmd.coef_wr = 1'b1;
            end else if (accept) begin
               cmd.start       = !series_ff;
               cmd.push_sample = 1'b1;
               half_in = half_now;
               last_in = req_last_sample;
               tap_in  = '0;
               if (req_last_sample) begin
                  series_in = 1'b0;
                  seen_in   = '0;
               end else begin
                  series_in = 1'b1;
                  seen_in   = cnt_now;
               end
               if (win_eff == '0) begin
                  state_in = ST_PASS;
               end else if (!req_last_sample) begin
                  rem_in = WW'(1);
                  if (cnt_now > {1'b0, half_now}) begin
                     state_in = ST_ISSUE;
                  end
               end else begin
                  // flush: pad the missing right side, then one result per shift
                  rem_in = res_cnt;
                  pre_in = half_p1 - res_cnt;
                  state_in = (half_p1 != res_cnt) ? ST_PAD : ST_ISSUE;
               end
            end
         end
         ST_PAD: begin
            cmd.push_pad = 1'b1;
            pre_in = pre_ff - 1'b1;
            if (pre_ff == WW'(1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_SHIFT: begin
            cmd.push_pad = 1'b1;
            tap_in   = '0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.tap_rd = 1'b1;
            tap_in = tap_ff + 1'b1;
            if (tap_ff == span) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // waits out the product and accumulate stages
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load_fir = 1'b1;
               cmd.out_last = last_ff && (rem_ff == WW'(1));
               rem_in = rem_ff - 1'b1;
               state_in = (rem_ff == WW'(1)) ? ST_IDLE : ST_SHIFT;
            end
         end
         ST_PASS: begin
            if (stat.out_free) begin
               cmd.load_pass = 1'b1;
               cmd.out_last  = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         series_ff   <= 1'b0;
         seen_ff     <= '0;
         window_ff   <= '0;
         pad_mode_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         series_ff <= series_in;
         seen_ff   <= seen_in;
         if (csr_we) begin
            case (csr_idx)
               gsf_pkg::REG_WINDOW_SIZE: window_ff   <= csr_wdata[WW-1:0];
               gsf_pkg::REG_PAD_MODE:    pad_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      half_ff  <= half_in;
      last_ff  <= last_in;
      pre_ff   <= pre_in;
      rem_ff   <= rem_in;
      tap_ff   <= tap_in;
      drain_ff <= drain_in;
   end

endmodule

FILE: rtl/core/gsf_dp.sv
module gsf_dp #(
   parameter int MAX_TAPS = gsf_pkg::DEF_MAX_TAPS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gsf_pkg::dp_cmd_type                   cmd,
   output gsf_pkg::dp_stat_type                  stat,
   input  logic signed [gsf_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [gsf_pkg::TAP_IDX_W-1:0]         req_tap_index,
   input  logic [gsf_pkg::WEIGHT_W-1:0]          req_tap_weight,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [gsf_pkg::SAMPLE_W-1:0]   rsp_smoothed,
   output logic                                  rsp_last_out
);

   localparam int AW = $clog2(MAX_TAPS);
   localparam int FW = $clog2(MAX_TAPS + 1);
   localparam int SW = gsf_pkg::SAMPLE_W;
   localparam int KW = gsf_pkg::WEIGHT_W;
   localparam int PW = gsf_pkg::PROD_W;
   localparam int CW = gsf_pkg::ACC_W;
   localparam int RW = CW + 1;

   logic signed [SW-1:0]  dline_mem [MAX_TAPS];
   logic [KW-1:0]         wt_mem [MAX_TAPS];

   logic [AW-1:0]         wp_ff, wp_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic signed [SW-1:0]  left_pad_ff;
   logic signed [SW-1:0]  sample_ff;

   logic signed [SW-1:0]  dl_q_ff;
   logic [KW-1:0]         wt_q_ff;
   logic                  in_fill_ff;
   logic                  v1_ff, first1_ff;
   logic signed [PW-1:0]  prod_ff;
   logic                  v2_ff, first2_ff;
   logic signed [CW-1:0]  acc_ff;

   logic                  out_valid_ff;
   logic signed [SW-1:0]  out_data_ff;
   logic                  out_last_ff;

   logic                  wr_en;
   logic signed [SW-1:0]  wr_data;
   logic [AW-1:0]         age_a;
   logic [AW:0]           rd_full;
   logic [AW-1:0]         rd_addr;
   logic signed [SW-1:0]  tap_val;
   logic signed [RW-1:0]  rounded;
   logic signed [31:0]    quot;
   logic signed [SW-1:0]  fir_val;

   assign stat.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_smoothed  = out_data_ff;
   assign rsp_last_out  = out_last_ff;

   assign wr_en   = cmd.push_sample || cmd.push_pad;
   assign wr_data = cmd.push_sample ? req_sample : (cmd.pad_zero ? '0 : sample_ff);

   always_comb begin
      wp_in = (wp_ff == AW'(MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
      if (cmd.start) begin
         fill_in = FW'(1);
      end else if (fill_ff == FW'(MAX_TAPS)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // circular line: newest entry sits at wp_ff, older ones below it
   always_comb begin
      age_a = AW'(cmd.age);
      if ({1'b0, wp_ff} >= {1'b0, age_a}) begin
         rd_full = {1'b0, wp_ff} - {1'b0, age_a};
      end else begin
         rd_full = {1'b0, wp_ff} + (AW+1)'(MAX_TAPS) - {1'b0, age_a};
      end
      rd_addr = rd_full[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (wr_en) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dline_mem[wp_in] <= wr_data;
      end
      if (cmd.tap_rd) begin
         dl_q_ff <= dline_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.coef_wr && (32'(req_tap_index) < 32'(MAX_TAPS))) begin
         wt_mem[AW'(req_tap_index)] <= req_tap_weight;
      end
      if (cmd.tap_rd) begin
         wt_q_ff <= wt_mem[AW'(cmd.tap)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         left_pad_ff <= cmd.pad_zero ? '0 : req_sample;
      end
      if (cmd.push_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.tap_rd) begin
         in_fill_ff <= 32'(cmd.age) < 32'(fill_ff);
      end
   end

   // entries at or beyond the fill level read as the left edge pad
   assign tap_val = in_fill_ff ? dl_q_ff : left_pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_rd;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= cmd.tap_rd && (cmd.tap == '0);
      first2_ff <= first1_ff;
      if (v1_ff) begin
         prod_ff <= tap_val * $signed({1'b0, wt_q_ff});
      end
      if (v2_ff) begin
         acc_ff <= first2_ff ? CW'(prod_ff) : acc_ff + CW'(prod_ff);
      end
   end

   // round half up then floor-shift, saturate to the sample range
   always_comb begin
      rounded = RW'(acc_ff) + RW'(65536);
      quot    = rounded[RW-1:gsf_pkg::FRAC_W];
      if (quot > 32'(gsf_pkg::SMP_MAX)) begin
         fir_val = gsf_pkg::SMP_MAX;
      end else if (quot < 32'(gsf_pkg::SMP_MIN)) begin
         fir_val = gsf_pkg::SMP_MIN;
      end else begin
         fir_val = quot[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_fir || cmd.load_pass) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_fir || cmd.load_pass) begin
         out_data_ff <= cmd.load_pass ? sample_ff : fir_val;
         out_last_ff <= cmd.out_last;
      end
   end

endmodule

FILE: rtl/core/gaussian_smoothing_fir.sv
// channel   dir  transfer when          payload
// req       in   req.valid & req.ready  kind, sample, last_sample, tap_index, tap_weight
// rsp       out  rsp.valid & rsp.ready  smoothed, last_out
// csr       in   csr_we                 csr_idx, csr_wdata
//
// Coefficient items and samples that give no result are taken in idle; passthrough
// goes through the pass state. A result for half-window p takes: accept, 2p+1 tap
// reads through one shared multiply-accumulate, the product and accumulate stages,
// output load. A last sample gives up to p+1 results and shifts in p pads in all.
// Reset is synchronous; delay line and weight memories are not cleared.
// A result waiting in the output register stalls only the next result.
module gaussian_smoothing_fir #(
   parameter int MAX_TAPS = gsf_pkg::DEF_MAX_TAPS
) (
   input  logic                              clock,
   input  logic                              reset,
   gsf_req_if.sink                           req,
   gsf_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [gsf_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [gsf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   gsf_pkg::dp_cmd_type  cmd;
   gsf_pkg::dp_stat_type stat;

   gsf_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req.valid),
      .req_kind        (req.kind),
      .req_last_sample (req.last_sample),
      .req_ready       (req.ready),
      .csr_we          (csr_we),
      .csr_idx         (csr_idx),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat)
   );

   gsf_dp #(
      .MAX_TAPS (MAX_TAPS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_sample     (req.sample),
      .req_tap_index  (req.tap_index),
      .req_tap_weight (req.tap_weight),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_smoothed   (rsp.smoothed),
      .rsp_last_out   (rsp.last_out)
   );

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_fir || cmd.load_pass) |-> stat.out_free)
      else $error("result loaded over an untaken result");

   a_coef_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.coef_wr |-> (req.ready && !cmd.tap_rd && !cmd.push_pad))
      else $error("coefficient write while busy");

   a_idle_no_mac: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (!cmd.tap_rd && !cmd.load_fir && !cmd.push_pad))
      else $error("datapath work while accepting");

endmodule
